### design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int TCW_COLS = 80;
  localparam int TCW_ROWS = 25;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic CFG_IDX_FG = 1'b0;
  localparam logic CFG_IDX_BG = 1'b1;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_value;
  } tcw_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep_row;
    logic sweep_full;
    logic sweep_step;
    logic init_fill;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic mode_clear;
    logic need_scroll;
    logic sweep_last;
  } tcw_stat_t;

endpackage

### design/text_console_writer.sv
`timescale 1ns / 1ps

// text console of COLS x ROWS 16-bit cells (attribute high byte, character low
// byte) with a cursor; each input transfer gives one result transfer carrying
// the cursor. a character, newline, read or unused mode goes from accept through
// one memory access to the result load; a step off the bottom row adds a sweep
// that blanks the new bottom row, and a clear adds a sweep of all ROWS*COLS
// cells, one cell per cycle through the single write port of the cell memory.
// scrolling moves a row pointer, not the cells. after reset the block blanks
// the whole memory before in_ready rises; configuration writes are taken
// during that time.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLS = TCW_COLS,
  parameter int ROWS = TCW_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  tcw_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output tcw_out_t   out_data
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

### design/tcw_datapath.sv
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; #(
  parameter int COLS = TCW_COLS,
  parameter int ROWS = TCW_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  input  tcw_in_t    in_data,
  input  tcw_cmd_t   cmd,
  output tcw_stat_t  stat,
  output tcw_out_t   out_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  logic [15:0]   mem [DEPTH];

  logic [3:0]    fg_r, bg_r;
  tcw_in_t       item_r;
  logic          in_range_r;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [AW-1:0] sweep_addr_r, sweep_end_r;
  logic [15:0]   rd_data_r;
  tcw_out_t      out_data_r;

  logic [15:0]   blank;
  logic          is_write, is_nl, wrap, last_row;
  logic [RW-1:0] cur_phys, rd_phys;
  logic [AW-1:0] wr_addr, rd_addr, top_base;

  // logical row to physical row through the circular top pointer
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, row};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  // the fill after reset always uses the reset colours
  assign blank    = cmd.init_fill ? {BG_RESET, FG_RESET, CH_SPACE} : {bg_r, fg_r, CH_SPACE};
  assign is_write = (item_r.mode == MODE_WRITE);
  assign is_nl    = (item_r.char_code == CH_NEWLINE);
  assign wrap     = is_nl || (cur_col_r == CW'(COLS - 1));
  assign last_row = (cur_row_r == RW'(ROWS - 1));

  assign cur_phys = phys_row(top_r, cur_row_r);
  assign rd_phys  = phys_row(top_r, RW'(item_r.read_row));
  assign wr_addr  = AW'(cur_phys) * AW'(COLS) + AW'(cur_col_r);
  assign rd_addr  = AW'(rd_phys) * AW'(COLS) + AW'(item_r.read_col);
  assign top_base = AW'(top_r) * AW'(COLS);

  assign stat.mode_clear  = (item_r.mode == MODE_CLEAR);
  assign stat.need_scroll = is_write && wrap && last_row;
  assign stat.sweep_last  = (sweep_addr_r == sweep_end_r);

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    top_nxt     = top_r;
    if (cmd.exec && is_write) begin
      if (wrap) begin
        cur_col_nxt = '0;
        if (last_row) begin
          top_nxt = phys_row(top_r, RW'(1));
        end else begin
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end else begin
        cur_col_nxt = cur_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r         <= FG_RESET;
      bg_r         <= BG_RESET;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= AW'(DEPTH - 1);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_FG: fg_r <= cfg_wdata;
          CFG_IDX_BG: bg_r <= cfg_wdata;
          default: ;
        endcase
      end
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      top_r     <= top_nxt;
      if (cmd.sweep_full) begin
        sweep_addr_r <= '0;
        sweep_end_r  <= AW'(DEPTH - 1);
      end else if (cmd.sweep_row) begin
        // new bottom row sits where the old top row was
        sweep_addr_r <= top_base;
        sweep_end_r  <= top_base + AW'(COLS - 1);
      end else if (cmd.sweep_step) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_data;
      in_range_r <= (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLS);
    end
    if (cmd.out_load) begin
      out_data_r.cursor_row <= 5'(cur_row_r);
      out_data_r.cursor_col <= 7'(cur_col_r);
      out_data_r.cell_value <= (item_r.mode == MODE_READ && in_range_r) ? rd_data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[sweep_addr_r] <= blank;
    end else if (cmd.exec && is_write && !is_nl) begin
      mem[wr_addr] <= {bg_r, fg_r, item_r.char_code};
    end
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_data = out_data_r;

endmodule

### design/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output tcw_cmd_t  cmd,
  input  tcw_stat_t stat
);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } tcw_state_t;

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.init_fill  = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.mode_clear) begin
          cmd.sweep_full = 1'b1;
          state_nxt      = ST_SWEEP;
        end else if (stat.need_scroll) begin
          cmd.sweep_row = 1'b1;
          state_nxt     = ST_SWEEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted item did not start execution");

  a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_SWEEP || state_r == ST_DONE)
    else $error("execution step repeated");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

endmodule
